### design/bcj_pkg.sv
// ----------------------------------------------------------------------------
// bcj_pkg
// shared types and constants for the de casteljau curve evaluator
// ----------------------------------------------------------------------------
package bcj_pkg;

  // curve size
  localparam int unsigned NUM_POINTS = 4;
  localparam int unsigned POINT_REGS = 4;
  localparam int unsigned NUM_ROUNDS = POINT_REGS - 1;
  localparam int unsigned DEG_MAX    = (NUM_POINTS - 1 < POINT_REGS - 1) ?
                                       (NUM_POINTS - 1) : (POINT_REGS - 1);

  // number formats
  localparam int unsigned CW   = 16;      // coordinate width, q3.12
  localparam int unsigned TW   = 17;      // parameter width, q1.16
  localparam int unsigned DW   = CW + 1;  // difference width
  localparam int unsigned PW   = DW + TW + 1;  // product width
  localparam logic [TW-1:0] T_ONE = TW'(65536);

  // register map
  localparam int unsigned IW = 3;
  localparam logic [IW-1:0] REG_DEGREE = 3'd0;
  localparam logic [IW-1:0] REG_POINT0 = 3'd1;
  localparam logic [IW-1:0] REG_POINT1 = 3'd2;
  localparam logic [IW-1:0] REG_POINT2 = 3'd3;
  localparam logic [IW-1:0] REG_POINT3 = 3'd4;

  // reset values
  localparam logic [1:0]  DEGREE_RST = 2'd2;
  localparam logic [47:0] POINT0_RST = 48'h0000_0000_0000;
  localparam logic [47:0] POINT1_RST = 48'h0000_1000_0000;
  localparam logic [47:0] POINT2_RST = 48'h0000_1000_1000;
  localparam logic [47:0] POINT3_RST = 48'h0000_0000_0000;

  // [coord] with x at 0, y at 1, z at 2
  typedef logic [2:0][CW-1:0] point_t;
  typedef point_t [POINT_REGS-1:0] pts_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef prod_t [NUM_ROUNDS-1:0][2:0] prods_t;

endpackage

### design/bcj_round.sv
// ----------------------------------------------------------------------------
// bcj_round
// one de casteljau round: a multiply stage then a round-and-add stage
// ----------------------------------------------------------------------------
module bcj_round (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               active_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [bcj_pkg::TW-1:0] t_i,
  input  bcj_pkg::pts_t      pts_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [bcj_pkg::TW-1:0] t_o,
  output bcj_pkg::pts_t      pts_o
);
  import bcj_pkg::*;

  logic          valid_a_q, valid_b_q;
  logic          ready_a, ready_b;
  logic [TW-1:0] t_a_q, t_b_q;
  pts_t          pts_a_q, pts_b_q;
  pts_t          pts_b_d;
  prods_t        prod_a_q, prod_a_d;

  assign ready_b = !valid_b_q || ready_i;
  assign ready_a = !valid_a_q || ready_b;
  assign ready_o = ready_a;

  // (q - p) * t for each neighbouring pair
  always_comb begin
    logic signed [DW-1:0] diff;
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      for (int c = 0; c < 3; c++) begin
        diff = $signed({pts_i[i+1][c][CW-1], pts_i[i+1][c]})
             - $signed({pts_i[i][c][CW-1], pts_i[i][c]});
        prod_a_d[i][c] = PW'(diff * $signed({1'b0, t_i}));
      end
    end
  end

  // p + floor((prod + half) / 2^16)
  always_comb begin
    prod_t sum;
    pts_b_d = pts_a_q;
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      for (int c = 0; c < 3; c++) begin
        sum = prod_a_q[i][c] + PW'(32768);
        if (active_i) begin
          pts_b_d[i][c] = pts_a_q[i][c] + sum[CW+15:16];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) valid_a_q <= valid_i;
      if (ready_b) valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      t_a_q    <= t_i;
      pts_a_q  <= pts_i;
      prod_a_q <= prod_a_d;
    end
    if (ready_b && valid_a_q) begin
      t_b_q   <= t_a_q;
      pts_b_q <= pts_b_d;
    end
  end

  assign valid_o = valid_b_q;
  assign t_o     = t_b_q;
  assign pts_o   = pts_b_q;

  // back-pressure only when both stages are full and blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (valid_a_q && valid_b_q && !ready_i))
    else $error("round stalls with room to spare");

  a_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_a_q && !ready_b) |=> (valid_a_q && $stable(prod_a_q)))
    else $error("blocked multiply stage changed");

  a_hold_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_b_q && !ready_i) |=> (valid_b_q && $stable(pts_b_q)))
    else $error("blocked result stage changed");

endmodule

### design/bezier_de_casteljau_eval.sv
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval
// bezier curve point by repeated fixed-point linear interpolation
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | t_i (q1.16, 65536 is one)
//  out     | source    | out_valid_o / out_stall_i| x_out_o, y_out_o, z_out_o (q3.12)
//  cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  one word per cycle in and out while out_stall_i is low; an input register,
//  then a multiply and a round-and-add register per round, three rounds
//  rounds past the degree pass point 0 through unchanged
//  reset clears valid bits and loads the register defaults; cfg is always ready
//  a stall on the output ripples back stage by stage; bubbles are squeezed out
// ----------------------------------------------------------------------------
module bezier_de_casteljau_eval (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [16:0]              t_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [15:0]       x_out_o,
  output logic signed [15:0]       y_out_o,
  output logic signed [15:0]       z_out_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bcj_pkg::IW-1:0]   cfg_index_i,
  input  logic [47:0]              cfg_data_i
);
  import bcj_pkg::*;

  // configuration registers
  logic [1:0]  degree_q;
  logic [47:0] point_q [POINT_REGS];

  // input register
  logic          valid_0_q;
  logic [TW-1:0] t_0_q, t_0_d;
  pts_t          pts_0_q, pts_0_d;
  logic          ready_0;

  // round chain, index 0 is the input register
  logic          rvalid [NUM_ROUNDS+1];
  logic          rready [NUM_ROUNDS+1];
  logic [TW-1:0] rt     [NUM_ROUNDS+1];
  pts_t          rpts   [NUM_ROUNDS+1];

  logic [1:0] deg_eff;

  assign cfg_ready_o = 1'b1;

  // config writes, out-of-range indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q   <= DEGREE_RST;
      point_q[0] <= POINT0_RST;
      point_q[1] <= POINT1_RST;
      point_q[2] <= POINT2_RST;
      point_q[3] <= POINT3_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DEGREE: degree_q   <= cfg_data_i[1:0];
        REG_POINT0: point_q[0] <= cfg_data_i;
        REG_POINT1: point_q[1] <= cfg_data_i;
        REG_POINT2: point_q[2] <= cfg_data_i;
        REG_POINT3: point_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // degree limited to the points available
  assign deg_eff = (32'(degree_q) > DEG_MAX) ? 2'(DEG_MAX) : degree_q;

  // t above one saturates to one; unpack the control points
  always_comb begin
    t_0_d = (t_i > T_ONE) ? T_ONE : t_i;
    for (int i = 0; i < POINT_REGS; i++) begin
      for (int c = 0; c < 3; c++) begin
        pts_0_d[i][c] = point_q[i][16*c +: 16];
      end
    end
  end

  assign ready_0    = !valid_0_q || rready[1];
  assign in_stall_o = !ready_0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_0_q <= 1'b0;
    end else if (ready_0) begin
      valid_0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_0 && in_valid_i) begin
      t_0_q   <= t_0_d;
      pts_0_q <= pts_0_d;
    end
  end

  assign rvalid[0] = valid_0_q;
  assign rt[0]     = t_0_q;
  assign rpts[0]   = pts_0_q;
  assign rready[0] = ready_0;

  // one interpolation round per instance; config must be kept steady while words fly (the block does not enforce it)
  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    logic active;
    assign active = (r <= 32'(deg_eff));

    bcj_round u_round (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (active),
      .valid_i  (rvalid[r-1]),
      .ready_o  (rready[r]),
      .t_i      (rt[r-1]),
      .pts_i    (rpts[r-1]),
      .valid_o  (rvalid[r]),
      .ready_i  ((r == NUM_ROUNDS) ? !out_stall_i : rready[(r < NUM_ROUNDS) ? r+1 : r]),
      .t_o      (rt[r]),
      .pts_o    (rpts[r])
    );
  end

  // last round holds the output word
  assign out_valid_o = rvalid[NUM_ROUNDS];
  assign x_out_o     = $signed(rpts[NUM_ROUNDS][0][0]);
  assign y_out_o     = $signed(rpts[NUM_ROUNDS][0][1]);
  assign z_out_o     = $signed(rpts[NUM_ROUNDS][0][2]);

  // saturated parameter never exceeds one
  a_t_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_0_q |-> (t_0_q <= T_ONE))
    else $error("parameter above one in pipeline");

  // input back-pressure only when the whole chain is blocked
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (valid_0_q && out_valid_o && out_stall_i))
    else $error("input stalled with free stages");

  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(deg_eff) <= DEG_MAX)
    else $error("effective degree out of range");

endmodule
